// ===== rtl/ttec_pkg.sv =====
// Shared constants for the tab expansion and clipping block.
// Holds character codes, register indexes and reset values; depends on nothing.
`default_nettype none

package ttec_pkg;

  localparam int unsigned LINE_MAX_DEFAULT = 4096;

  localparam logic [7:0] TAB_CODE   = 8'd9;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_TAB_STOP_WIDTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_COLUMN  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_ENABLE    = 4'd3;

  localparam logic [4:0]  TAB_STOP_WIDTH_RESET = 5'd4;
  localparam logic [4:0]  TAB_STOP_WIDTH_MAX   = 5'd16;
  localparam logic [11:0] SCROLL_COLUMN_RESET  = 12'd0;
  localparam logic [11:0] SCREEN_WIDTH_RESET   = 12'd80;
  localparam logic        WRAP_ENABLE_RESET    = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/text_line_tab_expand_clip.sv =====
// Tab expansion with horizontal scroll and clip for one text line.
// Uses ttec_pkg for character codes, register indexes and reset values.
`default_nettype none

// The input channel takes one raw character word per accepted transfer, with
// line_last set on the final character of a line. Each tab is expanded into
// spaces up to the next tab stop. Expanded positions left of scroll_column are
// skipped, and unless wrap_enable is set, positions at or beyond screen_width
// columns past the scroll point are clipped. Each visible position leaves as
// one output word carrying the character and its screen column. The last word
// of a line has line_done set; a line whose final character yields nothing
// visible ends with a bare marker word (char_valid low).
//
// A single placement step handles one expanded position per cycle, unless
// the output stalls, under a small sequencer. A plain character is accepted,
// then placed; a tab is accepted, then placed as spaces up to the next stop
// (1..16 of them). A dropped character is accepted and, when it ends the
// line, followed by a marker. Input stall is high while an item is in work.
// Output words sit in a register; while the receiver stalls, placement waits
// and the word is held. Reset clears the line state and loads the register
// defaults (tab width 4, scroll 0, width 80, wrap on). Configuration writes
// are taken in any cycle and are meant to happen while the block is idle.

module text_line_tab_expand_clip #(
  parameter int unsigned LINE_MAX = ttec_pkg::LINE_MAX_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ttec_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ttec_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input character channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        char_code,
  input  wire logic                              line_last,
  // Output channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_char,
  output logic [11:0]                            disp_col,
  output logic                                   char_valid,
  output logic                                   line_done
);

  // Column counters must hold LINE_MAX-1; comparisons against the 12-bit
  // registers are done in a width that covers both.
  localparam int unsigned CW = $clog2(LINE_MAX);
  localparam int unsigned AW = (CW > 12) ? CW : 12;
  localparam logic [CW-1:0] CAP      = CW'(LINE_MAX - 1);
  localparam logic [CW-1:0] CAP_LAST = CW'(LINE_MAX - 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;

  // Configuration registers.
  logic [4:0]  tab_stop_width;
  logic [11:0] scroll_column;
  logic [11:0] screen_width;
  logic        wrap_enable;

  // Line and item state.
  logic [1:0]    state;
  logic [CW-1:0] expanded_col;
  logic [CW-1:0] raw_count;
  logic [3:0]    tab_phase;
  logic [4:0]    spaces_left;
  logic [7:0]    cur_char;
  logic          cur_last;
  logic          emitted;

  // Placement step signals.
  logic [AW-1:0] pos_w;
  logic [AW-1:0] scroll_w;
  logic [AW-1:0] width_w;
  logic [AW-1:0] sc_w;
  logic          visible;
  logic          edge_hit;
  logic          final_pos;
  logic          out_free;
  logic [3:0]    tab_phase_next;
  logic [4:0]    tab_spaces;
  logic          is_tab;
  logic          has_room;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    pos_w    = AW'(expanded_col);
    scroll_w = AW'(scroll_column);
    width_w  = AW'(screen_width);
    sc_w     = pos_w - scroll_w;
    visible  = (pos_w >= scroll_w) && (wrap_enable || (sc_w < width_w));
    // The position just before the clip edge is the last visible one.
    edge_hit = !wrap_enable && (({1'b0, sc_w} + (AW+1)'(1)) == {1'b0, width_w});
    // The current position is the item's last if the tab is used up or the
    // expanded limit is reached after it.
    final_pos = (spaces_left == 5'd1) || (expanded_col == CAP_LAST);
    tab_phase_next = (({1'b0, tab_phase} + 5'd1) >= tab_stop_width) ?
                     4'd0 : tab_phase + 4'd1;
    // A phase left beyond a shrunken tab width gives a single space.
    tab_spaces = ({1'b0, tab_phase} < tab_stop_width) ?
                 tab_stop_width - {1'b0, tab_phase} : 5'd1;
    is_tab   = (char_code == ttec_pkg::TAB_CODE);
    has_room = (raw_count < CAP) && (expanded_col < CAP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_stop_width <= ttec_pkg::TAB_STOP_WIDTH_RESET;
      scroll_column  <= ttec_pkg::SCROLL_COLUMN_RESET;
      screen_width   <= ttec_pkg::SCREEN_WIDTH_RESET;
      wrap_enable    <= ttec_pkg::WRAP_ENABLE_RESET;
      state          <= S_IDLE;
      expanded_col   <= '0;
      raw_count      <= '0;
      tab_phase      <= '0;
      spaces_left    <= '0;
      cur_last       <= 1'b0;
      emitted        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ttec_pkg::REG_TAB_STOP_WIDTH: begin
            // Only the low five bits count; zero or a value above 16 is ignored.
            if (cfg_data[4:0] != 5'd0 && cfg_data[4:0] <= ttec_pkg::TAB_STOP_WIDTH_MAX) begin
              tab_stop_width <= cfg_data[4:0];
            end
          end
          ttec_pkg::REG_SCROLL_COLUMN: scroll_column <= cfg_data;
          ttec_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          ttec_pkg::REG_WRAP_ENABLE:   wrap_enable   <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_last <= line_last;
            emitted  <= 1'b0;
            if (has_room) begin
              raw_count   <= raw_count + CW'(1);
              cur_char    <= is_tab ? ttec_pkg::SPACE_CODE : char_code;
              spaces_left <= is_tab ? tab_spaces : 5'd1;
              state       <= S_RUN;
            end else if (line_last) begin
              // Dropped character that still ends the line.
              state <= S_MARK;
            end
          end
        end

        S_RUN: begin
          if (out_free) begin
            expanded_col <= expanded_col + CW'(1);
            tab_phase    <= tab_phase_next;
            spaces_left  <= spaces_left - 5'd1;
            if (visible) begin
              out_valid  <= 1'b1;
              out_char   <= cur_char;
              disp_col   <= sc_w[11:0];
              char_valid <= 1'b1;
              line_done  <= cur_last && (final_pos || edge_hit);
              emitted    <= 1'b1;
            end
            if (final_pos) begin
              spaces_left <= '0;
              if (cur_last && !emitted && !visible) begin
                state <= S_MARK;
              end else begin
                if (cur_last) begin
                  expanded_col <= '0;
                  tab_phase    <= '0;
                  raw_count    <= '0;
                end
                state <= S_IDLE;
              end
            end
          end
        end

        S_MARK: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_char     <= 8'd0;
            disp_col     <= 12'd0;
            char_valid   <= 1'b0;
            line_done    <= 1'b1;
            expanded_col <= '0;
            tab_phase    <= '0;
            raw_count    <= '0;
            spaces_left  <= '0;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/text_line_tab_expand_clip_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_line_tab_expand_clip: feeds text lines one
// character word at a time and checks every screen word against a local model.
// Depends on ttec_pkg and the text_line_tab_expand_clip RTL only.

module text_line_tab_expand_clip_tb;
  import ttec_pkg::*;

  // Expanded and raw positions of a line must stay below this limit.
  localparam int unsigned LINE_CAP = LINE_MAX_DEFAULT - 1;
  // A tab never gives more than one full stop of spaces.
  localparam int unsigned MAX_WORDS_PER_CHAR = 16;
  // Register index that the block does not decode; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'd15;
  // A tab of 16 hidden spaces keeps the block busy without producing a word,
  // so this many quiet cycles are allowed before reconfiguring.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_CHARS = 6;
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       hold_for_drain;
  } char_word_t;

  typedef struct {
    logic [7:0]  ch;
    logic [11:0] col;
    logic        visible;
    logic        done;
  } screen_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             char_code = '0;
  logic                   line_last = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_char;
  logic [11:0]            disp_col;
  logic                   char_valid;
  logic                   line_done;

  text_line_tab_expand_clip u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .line_last  (line_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .disp_col   (disp_col),
    .char_valid (char_valid),
    .line_done  (line_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Character words waiting to be sent, and screen words that the block owes.
  char_word_t   pending_chars[$];
  screen_word_t expected_words[$];
  // Scratch list of the words that one character produces.
  screen_word_t step_words[$];

  // Register copy, updated when a write handshake completes.
  logic [4:0]  tab_width_q;
  logic [11:0] scroll_q;
  logic [11:0] width_q;
  logic        wrap_q;

  // Line state of the model copy. The column and phase carry across
  // characters until a line ends, and also across reconfiguration.
  logic [11:0] line_col;
  logic [3:0]  stop_phase;
  logic [11:0] raw_seen;
  logic [4:0]  spaces_due;

  // Random idling of both sides; switched off for one random phase so that
  // back-to-back traffic is covered as well.
  logic        idle_on = 1'b1;
  bit          driving = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Mirrors a register write. The tab width field keeps only its low five
  // bits, and a width of zero or above sixteen leaves the old value in place.
  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TAB_STOP_WIDTH: begin
        if (data[4:0] != 5'd0 && data[4:0] <= TAB_STOP_WIDTH_MAX) begin
          tab_width_q = data[4:0];
        end
      end
      REG_SCROLL_COLUMN: scroll_q = data;
      REG_SCREEN_WIDTH:  width_q = data;
      REG_WRAP_ENABLE:   wrap_q = data[0];
      default: ;
    endcase
  endfunction

  // One expanded position: it always advances the column and the tab phase,
  // but only lands on screen when it is at or right of the scroll point and,
  // with wrap off, left of the visible width.
  function automatic void place_column(input logic [7:0] ch);
    logic [11:0]  pos;
    screen_word_t w;
    pos = line_col;
    line_col = pos + 12'd1;
    stop_phase = (int'(stop_phase) + 1 >= int'(tab_width_q)) ? 4'd0 : stop_phase + 4'd1;
    if (pos < scroll_q) return;
    w.col = pos - scroll_q;
    if (!wrap_q && w.col >= width_q) return;
    if (step_words.size() >= MAX_WORDS_PER_CHAR) return;
    w.ch = ch;
    w.visible = 1'b1;
    w.done = 1'b0;
    step_words.push_back(w);
  endfunction

  // Works out the screen words of one accepted character and queues them.
  function automatic void predict_screen_words(input logic [7:0] code, input logic last);
    screen_word_t w;
    step_words.delete();
    // Characters past the line limits are dropped, but an end of line on
    // them still counts.
    if (raw_seen < LINE_CAP && line_col < LINE_CAP) begin
      raw_seen = raw_seen + 12'd1;
      if (code == TAB_CODE) begin
        // A phase left above a shrunken width gives a single space.
        spaces_due = (stop_phase < tab_width_q) ? tab_width_q - stop_phase : 5'd1;
        while (spaces_due != 5'd0 && line_col < LINE_CAP) begin
          place_column(SPACE_CODE);
          spaces_due = spaces_due - 5'd1;
        end
        spaces_due = 5'd0;
      end else begin
        place_column(code);
      end
    end
    if (last) begin
      if (step_words.size() > 0) begin
        // The end of line rides on the last visible word of this character.
        w = step_words.pop_back();
        w.done = 1'b1;
        step_words.push_back(w);
      end else begin
        // Nothing visible: the line closes with a bare marker word.
        w.ch = 8'd0;
        w.col = 12'd0;
        w.visible = 1'b0;
        w.done = 1'b1;
        step_words.push_back(w);
      end
      line_col = '0;
      stop_phase = '0;
      raw_seen = '0;
      spaces_due = '0;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  function automatic void queue_char(input logic [7:0] code, input logic last,
                                     input logic hold);
    char_word_t c;
    c.code = code;
    c.last = last;
    c.hold_for_drain = hold;
    pending_chars.push_back(c);
  endfunction

  // Character driver. A word stays on the bus until the block takes it; the
  // prediction is made at that very edge, from the values the block saw. The
  // gap before the next word is drawn per word, and a word marked for it is
  // held back until every owed screen word has come out.
  always @(posedge clk) begin : drive_chars
    char_word_t next_char;
    if (rst) begin
      driving = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_screen_words(char_code, line_last);
        driving = 1'b0;
        gap_left = idle_on ? $urandom_range(11, 0) : 0;
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_chars.size() != 0 &&
                     !(pending_chars[0].hold_for_drain && expected_words.size() != 0)) begin
          next_char = pending_chars.pop_front();
          char_code <= next_char.code;
          line_last <= next_char.last;
          driving = 1'b1;
        end
      end
    end
    in_valid <= driving;
  end

  // Screen word monitor. Every accepted word is checked field by field
  // against the oldest owed word; after each one the receiver draws how many
  // cycles it stalls before it takes the next.
  always @(posedge clk) begin : watch_screen
    screen_word_t want;
    if (rst) begin
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%0d col=%0d valid=%0b done=%0b",
                                    out_char, disp_col, char_valid, line_done));
        end else begin
          want = expected_words.pop_front();
          if (out_char !== want.ch)
            report_mismatch($sformatf("out_char %0d, want %0d", out_char, want.ch));
          if (disp_col !== want.col)
            report_mismatch($sformatf("disp_col %0d, want %0d", disp_col, want.col));
          if (char_valid !== want.visible)
            report_mismatch($sformatf("char_valid %0b, want %0b", char_valid, want.visible));
          if (line_done !== want.done)
            report_mismatch($sformatf("line_done %0b, want %0b", line_done, want.done));
        end
        stall_left = idle_on ? $urandom_range(11, 0) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (stall_left != 0);
  end

  // Starts a register write at the current edge and returns at the edge that
  // completes it. Valid is left high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, data);
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] tab_stop,
                                input logic [CFG_DATA_W-1:0] scroll,
                                input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] wrap);
    write_reg(REG_TAB_STOP_WIDTH, tab_stop);
    write_reg(REG_SCROLL_COLUMN, scroll);
    write_reg(REG_SCREEN_WIDTH, width);
    write_reg(REG_WRAP_ENABLE, wrap);
    cfg_valid <= 1'b0;
  endtask

  // Returns once every character is in, every owed word is out, and the
  // block has had time to finish a character that produces no word.
  task automatic wait_for_drain();
    while (pending_chars.size() != 0 || driving || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned sent;
    int unsigned line_chars;
    logic        keep_open;
    logic [4:0]  tab_stop;
    logic [11:0] scroll;
    logic [11:0] width;
    logic [7:0]  code;

    tab_width_q = TAB_STOP_WIDTH_RESET;
    scroll_q = SCROLL_COLUMN_RESET;
    width_q = SCREEN_WIDTH_RESET;
    wrap_q = WRAP_ENABLE_RESET;
    line_col = '0;
    stop_phase = '0;
    raw_seen = '0;
    spaces_due = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: character extremes and tabs at different phases, then
    // a line made of a single tab.
    queue_char(8'h41, 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'hFF, 1'b0, 1'b0);
    queue_char(8'h00, 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'h7E, 1'b1, 1'b0);
    queue_char(TAB_CODE, 1'b1, 1'b0);
    wait_for_drain();

    // Bad tab widths and an undecoded index must change nothing. Then a
    // narrow window: tab width 1, scroll 2, three columns, clipping on. The
    // line's final character falls outside, so it ends with a bare marker.
    write_reg(REG_TAB_STOP_WIDTH, 12'd0);
    write_reg(REG_TAB_STOP_WIDTH, 12'd17);
    write_reg(REG_TAB_STOP_WIDTH, 12'd31);
    write_reg(REG_SPARE, 12'hFFF);
    write_all_regs(12'd1, 12'd2, 12'd3, 12'd0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'h61, 1'b0, 1'b0);
    queue_char(8'h62, 1'b0, 1'b0);
    queue_char(8'h63, 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'h64, 1'b1, 1'b0);
    wait_for_drain();

    // Zero screen width with clipping: nothing is visible at all.
    write_all_regs(12'd16, 12'd0, 12'd0, 12'd0);
    queue_char(8'h71, 1'b0, 1'b1);
    queue_char(TAB_CODE, 1'b1, 1'b0);
    wait_for_drain();

    // A full sixteen-space tab, then a line left open at phase 5 while the
    // tab width drops to 3. The next tab then gives a single space.
    write_all_regs(12'd16, 12'd0, 12'd4095, 12'd1);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) queue_char(8'h61 + 8'(i), 1'b0, 1'b0);
    wait_for_drain();
    write_reg(REG_TAB_STOP_WIDTH, 12'd3);
    cfg_valid <= 1'b0;
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'h7A, 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b1, 1'b0);
    wait_for_drain();

    // Line limits: 255 full tabs and 14 characters fill all but the last
    // kept position, the next tab is cut short after one space, and the rest
    // of the line is dropped, its end still honored with a marker. Scrolled
    // far right so only the tail of the line shows. The line after it must
    // start from column zero again.
    write_all_regs(12'd16, 12'd4085, 12'd4095, 12'd1);
    for (int i = 0; i < 255; i++) queue_char(TAB_CODE, 1'b0, 1'b0);
    for (int i = 0; i < 14; i++) queue_char(8'h41 + 8'(i), 1'b0, 1'b0);
    queue_char(TAB_CODE, 1'b0, 1'b0);
    queue_char(8'h58, 1'b0, 1'b0);
    queue_char(8'h59, 1'b1, 1'b0);
    queue_char(8'h6B, 1'b1, 1'b0);
    wait_for_drain();

    // Random lines under a new setting per phase. The first phases pin the
    // register extremes; a phase may end in the middle of a line so that the
    // next setting applies to a line already under way.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != 1);
      tab_stop = (phase == 0) ? 5'd1 : (phase == 1) ? 5'd16 : 5'($urandom_range(16, 1));
      scroll = (phase == 2) ? 12'd4095 :
               (phase == 4) ? 12'($urandom_range(4095, 0)) : 12'($urandom_range(12, 0));
      width = (phase == 0) ? 12'd1 :
              (phase == 3) ? 12'd4095 : 12'($urandom_range(40, 1));
      if ($urandom_range(2, 0) == 0) begin
        write_reg(REG_TAB_STOP_WIDTH, ($urandom_range(1, 0) == 0) ? 12'd0
                                      : 12'($urandom_range(31, 17)));
      end
      write_all_regs({7'($urandom), tab_stop}, scroll, width,
                     {11'($urandom), phase[0] ^ (phase >= 3)});
      sent = 0;
      while (sent < PHASE_CHARS) begin
        line_chars = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 30)
                                                  : $urandom_range(16, 1);
        keep_open = (sent + line_chars >= PHASE_CHARS) && ($urandom_range(1, 0) == 0);
        for (int k = 0; k < line_chars; k++) begin
          code = ($urandom_range(3, 0) == 0) ? TAB_CODE : 8'($urandom);
          queue_char(code, (k == line_chars - 1) && !keep_open,
                     (k == 0) && ($urandom_range(15, 0) == 0));
        end
        sent += line_chars;
      end
      wait_for_drain();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every character at full tab length
  // against the longest receiver stall and sender gap.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
